### rtl/cop_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cop_pkg
// Shared widths and the control bundle for the circle overlap push pipeline.
// ----------------------------------------------------------------------------
package cop_pkg;

  localparam int PosW  = 24;            // position field width
  localparam int SizeW = 20;            // box size field width
  localparam int PushW = 21;            // push field width
  localparam int DltW  = PosW + 1;      // center offset width
  localparam int SumW  = SizeW + 2;     // sum of four sizes
  localparam int SqW   = 2 * DltW;      // dx^2 + dy^2 with carry
  localparam int HitW  = 40;            // squared distance bits that matter on a hit
  localparam int RadW  = HitW + 16;     // radicand, squared distance in Q.16
  localparam int RootW = RadW / 2;      // distance in Q.8
  localparam int RemW  = RootW + 3;     // square-root partial remainder
  localparam int MagW  = 20;            // axis magnitude on a hit
  localparam int ProdW = MagW + RootW;  // magnitude times overlap
  localparam int NumW  = ProdW + 1;     // dividend with rounding term
  localparam int QW    = PushW;         // quotient bits

  localparam logic [PushW-1:0] PushMax = {1'b0, {(PushW-1){1'b1}}};

  typedef struct packed {
    logic             hit;
    logic             act;     // hit with nonzero offset
    logic             neg_x;   // push x is negative
    logic             neg_y;
    logic [MagW-1:0]  mag_x;
    logic [MagW-1:0]  mag_y;
    logic [RootW-1:0] r16;     // summed radii in Q.8
  } cop_ctl_t;

endpackage
`default_nettype wire

### rtl/cop_ifs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cop_ifs
// Valid/ready channels for object pairs and push results.
// ----------------------------------------------------------------------------
interface cop_in_if;
  import cop_pkg::*;
  logic             valid;
  logic             ready;
  logic [PosW-1:0]  player_x;
  logic [PosW-1:0]  player_y;
  logic [SizeW-1:0] player_width;
  logic [SizeW-1:0] player_height;
  logic [PosW-1:0]  target_x;
  logic [PosW-1:0]  target_y;
  logic [SizeW-1:0] target_width;
  logic [SizeW-1:0] target_height;

  modport source (output valid, player_x, player_y, player_width, player_height,
                  target_x, target_y, target_width, target_height, input ready);
  modport sink (input valid, player_x, player_y, player_width, player_height,
                target_x, target_y, target_width, target_height, output ready);
endinterface

interface cop_out_if;
  import cop_pkg::*;
  logic             valid;
  logic             ready;
  logic             hit;
  logic [PushW-1:0] push_x;
  logic [PushW-1:0] push_y;

  modport source (output valid, hit, push_x, push_y, input ready);
  modport sink (input valid, hit, push_x, push_y, output ready);
endinterface
`default_nettype wire

### rtl/circle_overlap_push_resolve_top.sv
`default_nettype none
// Throughput: one beat per cycle unless out_ch stalls; the 28-step square-root
// chain and the 21-step divider chains are fully unrolled into register stages.
// A stall on out_ch freezes every stage at once; nothing is dropped.
// Reset (rst_n low, synchronous) clears all valid bits; payload is not reset.
// ----------------------------------------------------------------------------
// circle_overlap_push_resolve_top
// Circle-circle hit test with an overlap push vector, fully pipelined.
// ----------------------------------------------------------------------------
module circle_overlap_push_resolve_top (
  input  wire logic clk,
  input  wire logic rst_n,
  cop_in_if.sink    in_ch,
  cop_out_if.source out_ch
);
  import cop_pkg::*;

  localparam int SqSteps  = RootW;
  localparam int DivSteps = QW;

  // Global advance: every stage moves when the output register can empty.
  logic adv;
  logic out_v_r;
  assign adv         = !out_v_r || out_ch.ready;
  assign in_ch.ready = adv;

  // --------------------------------------------------------------------------
  // Stage 1: center offset and size sum.
  // --------------------------------------------------------------------------
  logic            v1_r;
  logic [DltW-1:0] dx1_r, dy1_r;
  logic [SumW-1:0] s1_r;
  logic [DltW-1:0] dx_nxt, dy_nxt;
  logic [SumW-1:0] s_nxt;

  always_comb begin
    dx_nxt = {in_ch.target_x[PosW-1], in_ch.target_x}
           - {in_ch.player_x[PosW-1], in_ch.player_x};
    dy_nxt = {in_ch.target_y[PosW-1], in_ch.target_y}
           - {in_ch.player_y[PosW-1], in_ch.player_y};
    s_nxt  = {2'b00, in_ch.player_width} + {2'b00, in_ch.player_height}
           + {2'b00, in_ch.target_width} + {2'b00, in_ch.target_height};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dx1_r <= dx_nxt;
      dy1_r <= dy_nxt;
      s1_r  <= s_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: magnitudes and squares.
  // --------------------------------------------------------------------------
  logic              v2_r;
  logic [SqW-1:0]    sqx2_r, sqy2_r;
  logic [2*SumW-1:0] ssq2_r;
  logic              negx2_r, negy2_r;
  logic [MagW-1:0]   magx2_r, magy2_r;
  logic [RootW-1:0]  r16_2_r;
  logic [DltW-1:0]   adx, ady;

  always_comb begin
    adx = dx1_r[DltW-1] ? (~dx1_r + 1'b1) : dx1_r;
    ady = dy1_r[DltW-1] ? (~dy1_r + 1'b1) : dy1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sqx2_r  <= adx * adx;
      sqy2_r  <= ady * ady;
      ssq2_r  <= s1_r * s1_r;
      // A positive offset pushes the player toward negative values.
      negx2_r <= !dx1_r[DltW-1] && (dx1_r != '0);
      negy2_r <= !dy1_r[DltW-1] && (dy1_r != '0);
      magx2_r <= adx[MagW-1:0];
      magy2_r <= ady[MagW-1:0];
      r16_2_r <= {s1_r, 6'b0};
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: exact hit test (16*d2 < S^2), load the square-root chain.
  // --------------------------------------------------------------------------
  logic [SqW-1:0] d2;
  logic           hit3;

  always_comb begin
    d2   = sqx2_r + sqy2_r;
    hit3 = {d2, 4'b0} < {{(SqW+4-2*SumW){1'b0}}, ssq2_r};
  end

  logic           sq_v_r    [0:SqSteps];
  cop_ctl_t       sq_ctl_r  [0:SqSteps];
  logic [RadW-1:0]  sq_rad_r  [0:SqSteps];
  logic [RemW-1:0]  sq_rem_r  [0:SqSteps];
  logic [RootW-1:0] sq_root_r [0:SqSteps];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r[0] <= 1'b0;
    end else if (adv) begin
      sq_v_r[0] <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_ctl_r[0].hit   <= hit3;
      sq_ctl_r[0].act   <= hit3 && (d2 != '0);
      sq_ctl_r[0].neg_x <= negx2_r;
      sq_ctl_r[0].neg_y <= negy2_r;
      sq_ctl_r[0].mag_x <= magx2_r;
      sq_ctl_r[0].mag_y <= magy2_r;
      sq_ctl_r[0].r16   <= r16_2_r;
      // On a hit d2 stays below 2^40; other items are masked at the end.
      sq_rad_r[0]       <= {d2[HitW-1:0], 16'b0};
      sq_rem_r[0]       <= '0;
      sq_root_r[0]      <= '0;
    end
  end

  // --------------------------------------------------------------------------
  // Square root: one root bit per stage, two radicand bits consumed each.
  // --------------------------------------------------------------------------
  for (genvar k = 0; k < SqSteps; k++) begin : g_sqrt
    logic [RemW-1:0]  rem_sh, trial, rem_nxt;
    logic [RootW-1:0] root_nxt;

    always_comb begin
      rem_sh = {sq_rem_r[k][RemW-3:0], sq_rad_r[k][RadW-1 -: 2]};
      trial  = {1'b0, sq_root_r[k], 2'b01};
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sh - trial;
        root_nxt = {sq_root_r[k][RootW-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh;
        root_nxt = {sq_root_r[k][RootW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[k+1] <= 1'b0;
      end else if (adv) begin
        sq_v_r[k+1] <= sq_v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_ctl_r[k+1]  <= sq_ctl_r[k];
        sq_rad_r[k+1]  <= {sq_rad_r[k][RadW-3:0], 2'b00};
        sq_rem_r[k+1]  <= rem_nxt;
        sq_root_r[k+1] <= root_nxt;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Overlap: R16 - d16, clamped at zero.
  // --------------------------------------------------------------------------
  logic             va_r;
  cop_ctl_t         ctla_r;
  logic [RootW-1:0] ova_r, dena_r;
  logic [RootW-1:0] d16;

  assign d16 = sq_root_r[SqSteps];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (adv) begin
      va_r <= sq_v_r[SqSteps];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctla_r <= sq_ctl_r[SqSteps];
      dena_r <= d16;
      ova_r  <= (sq_ctl_r[SqSteps].r16 > d16) ? (sq_ctl_r[SqSteps].r16 - d16) : '0;
    end
  end

  // --------------------------------------------------------------------------
  // Scale each axis magnitude by the overlap.
  // --------------------------------------------------------------------------
  logic             vb_r;
  cop_ctl_t         ctlb_r;
  logic [RootW-1:0] denb_r;
  logic [ProdW-1:0] prodx_b_r, prody_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (adv) begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctlb_r    <= ctla_r;
      denb_r    <= dena_r;
      prodx_b_r <= ctla_r.mag_x * ova_r;
      prody_b_r <= ctla_r.mag_y * ova_r;
    end
  end

  // --------------------------------------------------------------------------
  // Rounded divide by d16: add half the divisor, then restoring long division,
  // one quotient bit per stage. The quotient stays below 2^21, so the top
  // dividend bits start out below the divisor.
  // --------------------------------------------------------------------------
  logic [NumW-1:0] numx, numy;

  always_comb begin
    numx = {1'b0, prodx_b_r} + {{(NumW-RootW+1){1'b0}}, denb_r[RootW-1:1]};
    numy = {1'b0, prody_b_r} + {{(NumW-RootW+1){1'b0}}, denb_r[RootW-1:1]};
  end

  logic             dv_v_r    [0:DivSteps];
  cop_ctl_t         dv_ctl_r  [0:DivSteps];
  logic [RootW-1:0] dv_den_r  [0:DivSteps];
  logic [RootW-1:0] dv_remx_r [0:DivSteps];
  logic [RootW-1:0] dv_remy_r [0:DivSteps];
  logic [QW-1:0]    dv_numx_r [0:DivSteps];
  logic [QW-1:0]    dv_numy_r [0:DivSteps];
  logic [QW-1:0]    dv_qx_r   [0:DivSteps];
  logic [QW-1:0]    dv_qy_r   [0:DivSteps];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else if (adv) begin
      dv_v_r[0] <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_ctl_r[0]  <= ctlb_r;
      dv_den_r[0]  <= denb_r;
      dv_remx_r[0] <= numx[NumW-1 -: RootW];
      dv_remy_r[0] <= numy[NumW-1 -: RootW];
      dv_numx_r[0] <= numx[QW-1:0];
      dv_numy_r[0] <= numy[QW-1:0];
      dv_qx_r[0]   <= '0;
      dv_qy_r[0]   <= '0;
    end
  end

  for (genvar j = 0; j < DivSteps; j++) begin : g_div
    logic [RootW:0]   tx, ty, dext;
    logic [RootW-1:0] remx_nxt, remy_nxt;
    logic             bx, by;

    always_comb begin
      dext = {1'b0, dv_den_r[j]};
      tx   = {dv_remx_r[j], dv_numx_r[j][QW-1]};
      ty   = {dv_remy_r[j], dv_numy_r[j][QW-1]};
      bx   = tx >= dext;
      by   = ty >= dext;
      remx_nxt = bx ? RootW'(tx - dext) : tx[RootW-1:0];
      remy_nxt = by ? RootW'(ty - dext) : ty[RootW-1:0];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[j+1] <= 1'b0;
      end else if (adv) begin
        dv_v_r[j+1] <= dv_v_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_ctl_r[j+1]  <= dv_ctl_r[j];
        dv_den_r[j+1]  <= dv_den_r[j];
        dv_remx_r[j+1] <= remx_nxt;
        dv_remy_r[j+1] <= remy_nxt;
        dv_numx_r[j+1] <= {dv_numx_r[j][QW-2:0], 1'b0};
        dv_numy_r[j+1] <= {dv_numy_r[j][QW-2:0], 1'b0};
        dv_qx_r[j+1]   <= {dv_qx_r[j][QW-2:0], bx};
        dv_qy_r[j+1]   <= {dv_qy_r[j][QW-2:0], by};
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register: apply sign, saturate, zero the push on a miss or on
  // coincident centers.
  // --------------------------------------------------------------------------
  cop_ctl_t         ctlz;
  logic [QW-1:0]    qx, qy;
  logic [PushW-1:0] pushx_nxt, pushy_nxt;
  logic             hit_r;
  logic [PushW-1:0] pushx_r, pushy_r;

  always_comb begin
    ctlz = dv_ctl_r[DivSteps];
    qx   = dv_qx_r[DivSteps];
    qy   = dv_qy_r[DivSteps];
    if (!ctlz.act) begin
      pushx_nxt = '0;
    end else if (ctlz.neg_x) begin
      pushx_nxt = ~qx + 1'b1;
    end else begin
      pushx_nxt = (qx > PushMax) ? PushMax : qx;
    end
    if (!ctlz.act) begin
      pushy_nxt = '0;
    end else if (ctlz.neg_y) begin
      pushy_nxt = ~qy + 1'b1;
    end else begin
      pushy_nxt = (qy > PushMax) ? PushMax : qy;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= dv_v_r[DivSteps];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hit_r   <= ctlz.hit;
      pushx_r <= pushx_nxt;
      pushy_r <= pushy_nxt;
    end
  end

  assign out_ch.valid  = out_v_r;
  assign out_ch.hit    = hit_r;
  assign out_ch.push_x = pushx_r;
  assign out_ch.push_y = pushy_r;

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.hit |-> (out_ch.push_x == '0) && (out_ch.push_y == '0))
    else $error("push nonzero without a hit");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result valid right after reset");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> out_ch.valid && !out_ch.ready)
    else $error("input stalled with the output free");

  a_div_range: assert property (@(posedge clk) disable iff (!rst_n)
    dv_v_r[0] && dv_ctl_r[0].act |-> dv_remx_r[0] < dv_den_r[0])
    else $error("dividend overflows quotient width");

endmodule
`default_nettype wire

### tb/cop_push_monitor.sv
`timescale 1ns / 100ps
`default_nettype none
// ----------------------------------------------------------------------------
// cop_push_monitor
// Watches the pair and push channels, predicts hit and push vector for each
// accepted pair beat and compares result beats in order.
// ----------------------------------------------------------------------------
module cop_push_monitor (
  input  wire logic clk,
  input  wire logic rst_n,
  cop_in_if         in_ch,
  cop_out_if        out_ch,
  output int        mismatches,
  output int        pushes_due
);
  import cop_pkg::*;

  typedef struct packed {
    logic             hit;
    logic [PushW-1:0] push_x;
    logic [PushW-1:0] push_y;
  } push_res_t;

  push_res_t pushes_q[$];

  function automatic longint floor_root(input longint v);
    longint r, b, x;
    r = 0;
    x = v;
    b = 64'sd1 <<< 62;
    while (b > x) b = b >>> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  // Push along one axis: away from the target, rounded half away from zero.
  function automatic logic [PushW-1:0] axis_push(input longint delta, input longint ov,
                                                 input longint den);
    longint m, q, p;
    m = (delta < 0) ? -delta : delta;
    q = (m * ov + den / 2) / den;
    if (q > 1048576) q = 1048576;
    p = (delta > 0) ? -q : q;
    if (p > 1048575) p = 1048575;
    if (p < -1048576) p = -1048576;
    return p[PushW-1:0];
  endfunction

  function automatic push_res_t resolve_pair(
    input logic [PosW-1:0] px, py, tx, ty,
    input logic [SizeW-1:0] pw, ph, tw, th);
    push_res_t res;
    longint dx, dy, d2, s, d16, r16, ov;
    dx  = longint'($signed(tx)) - longint'($signed(px));
    dy  = longint'($signed(ty)) - longint'($signed(py));
    d2  = dx * dx + dy * dy;
    s   = longint'(pw) + longint'(ph) + longint'(tw) + longint'(th);
    res = '0;
    res.hit = (d2 * 16) < (s * s);
    // coincident centers: no direction, push stays zero
    if (res.hit && d2 != 0) begin
      d16 = floor_root(d2 <<< 16);
      r16 = s <<< 6;
      ov  = (r16 > d16) ? r16 - d16 : 0;
      res.push_x = axis_push(dx, ov, d16);
      res.push_y = axis_push(dy, ov, d16);
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("[%0t] push mismatch on %s: got %0h want %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    push_res_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (pushes_q.size() == 0) begin
          report_mismatch("unexpected beat", out_ch.hit, 0);
        end else begin
          want = pushes_q.pop_front();
          if (out_ch.hit !== want.hit) report_mismatch("hit", out_ch.hit, want.hit);
          if (out_ch.push_x !== want.push_x)
            report_mismatch("push_x", out_ch.push_x, want.push_x);
          if (out_ch.push_y !== want.push_y)
            report_mismatch("push_y", out_ch.push_y, want.push_y);
        end
      end
      if (in_ch.valid && in_ch.ready)
        pushes_q.push_back(resolve_pair(in_ch.player_x, in_ch.player_y, in_ch.target_x,
          in_ch.target_y, in_ch.player_width, in_ch.player_height, in_ch.target_width,
          in_ch.target_height));
    end
    pushes_due = pushes_q.size();
  end

endmodule
`default_nettype wire

### tb/circle_overlap_push_resolve_top_test.sv
`timescale 1ns / 100ps
`default_nettype none
// ----------------------------------------------------------------------------
// circle_overlap_push_resolve_top_test
// Streams object pairs into the push pipeline: directed corner pairs, then
// random pairs mostly placed near each other so that hits are common, under
// changing sender gaps and receiver stalls. A monitor predicts each result.
// ----------------------------------------------------------------------------
module circle_overlap_push_resolve_top_test;
  import cop_pkg::*;

  localparam int PipeDepth  = 56;
  localparam int CycleLimit = 200000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   mismatches;
  int   pushes_due;
  int   cycles = 0;
  int   send_idle_pct = 0;   // chance of a gap before each pair beat
  int   stall_pct = 0;       // chance the receiver holds ready low

  cop_in_if  in_ch ();
  cop_out_if out_ch ();

  circle_overlap_push_resolve_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  cop_push_monitor u_monitor (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .mismatches (mismatches),
    .pushes_due (pushes_due)
  );

  always #5 clk = ~clk;

  // Hard stop: far beyond the slowest legal run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Receiver: stall at random, one decision per cycle.
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Drive one pair beat. Enter and leave at a falling edge.
  task automatic send_pair(input logic [PosW-1:0] px, py, input logic [SizeW-1:0] pw, ph,
                           input logic [PosW-1:0] tx, ty, input logic [SizeW-1:0] tw, th);
    logic taken;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.player_x      <= px;
    in_ch.player_y      <= py;
    in_ch.player_width  <= pw;
    in_ch.player_height <= ph;
    in_ch.target_x      <= tx;
    in_ch.target_y      <= ty;
    in_ch.target_width  <= tw;
    in_ch.target_height <= th;
    // Hold the beat until the edge that accepts it.
    forever begin
      #4;
      taken = in_ch.ready;
      @(posedge clk);
      @(negedge clk);
      if (taken) break;
    end
  endtask

  function automatic logic [SizeW-1:0] rand_size();
    int unsigned bits;
    bits = $urandom_range(0, SizeW);
    return SizeW'($urandom & ((64'd1 << bits) - 1));
  endfunction

  // Random pair: mostly near each other (hits), sometimes coincident or anywhere.
  task automatic send_random_pair();
    logic [PosW-1:0]  px, py, tx, ty;
    logic [SizeW-1:0] pw, ph, tw, th;
    int unsigned      mode, reach;
    longint           s;
    px = PosW'($urandom);
    py = PosW'($urandom);
    mode = $urandom_range(0, 9);
    if (mode < 7) begin
      pw = rand_size(); ph = rand_size(); tw = rand_size(); th = rand_size();
    end else begin
      pw = SizeW'($urandom); ph = SizeW'($urandom);
      tw = SizeW'($urandom); th = SizeW'($urandom);
    end
    s = longint'(pw) + ph + tw + th;
    reach = int'(s / 4) + 1;
    if (mode < 6) begin
      tx = px + PosW'(int'($urandom_range(0, 2 * reach)) - int'(reach));
      ty = py + PosW'(int'($urandom_range(0, 2 * reach)) - int'(reach));
    end else if (mode == 6) begin
      tx = px;
      ty = py;
    end else begin
      tx = PosW'($urandom);
      ty = PosW'($urandom);
    end
    send_pair(px, py, pw, ph, tx, ty, tw, th);
  endtask

  task automatic wait_drained();
    while (pushes_due != 0) @(negedge clk);
  endtask

  localparam logic [PosW-1:0]  PosMax  = {1'b0, {(PosW-1){1'b1}}};
  localparam logic [PosW-1:0]  PosMin  = {1'b1, {(PosW-1){1'b0}}};
  localparam logic [SizeW-1:0] SizeMax = '1;

  initial begin
    in_ch.valid         = 1'b0;
    in_ch.player_x      = '0;
    in_ch.player_y      = '0;
    in_ch.player_width  = '0;
    in_ch.player_height = '0;
    in_ch.target_x      = '0;
    in_ch.target_y      = '0;
    in_ch.target_width  = '0;
    in_ch.target_height = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed corners, no idling.
    send_pair('0, '0, '0, '0, '0, '0, '0, '0);                       // zero size, same point
    send_pair(24'd100, 24'd100, '0, '0, 24'd200, 24'd100, '0, '0);   // zero size apart
    send_pair(PosMax, PosMax, SizeMax, SizeMax, PosMax, PosMax, SizeMax, SizeMax);
    send_pair(PosMin, PosMin, SizeMax, SizeMax, PosMax, PosMax, SizeMax, SizeMax);
    send_pair(PosMax, PosMin, SizeMax, SizeMax, PosMin, PosMax, SizeMax, SizeMax);
    // Exactly touching, then just inside, on both axes and both directions.
    send_pair('0, '0, 20'd100, 20'd100, 24'd100, '0, 20'd100, 20'd100);
    send_pair('0, '0, 20'd100, 20'd100, 24'd99, '0, 20'd100, 20'd100);
    send_pair('0, '0, 20'd100, 20'd100, -24'sd99, '0, 20'd100, 20'd100);
    send_pair('0, '0, 20'd100, 20'd100, '0, 24'd99, 20'd100, 20'd100);
    send_pair('0, '0, 20'd100, 20'd100, '0, -24'sd99, 20'd100, 20'd100);
    send_pair('0, '0, 20'd100, 20'd100, 24'd1, 24'd1, 20'd100, 20'd100);
    send_pair(24'd5, 24'd7, 20'd3, 20'd1, 24'd6, 24'd6, '0, '0);
    // Max sizes: a tiny offset and offsets beyond the reach; then uneven sizes.
    send_pair(PosMin, '0, SizeMax, SizeMax, PosMin + 24'd1, '0, SizeMax, SizeMax);
    send_pair('0, '0, SizeMax, SizeMax, 24'h1F_FFFF, 24'h1F_FFFF, SizeMax, SizeMax);
    send_pair('0, '0, SizeMax, SizeMax, -24'sh2A_0000, 24'h10_0000, SizeMax, SizeMax);
    send_pair(PosMax, PosMax, 20'h5_5555, 20'hA_AAAA, PosMax - 24'd3, PosMax, 20'h1, 20'h0);
    in_ch.valid <= 1'b0;

    // Hold off until every result is out, then let the pipe empty.
    @(negedge clk);
    wait_drained();
    repeat (PipeDepth) @(negedge clk);

    // Random phases: free flow, sender gaps, receiver stalls, both.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 60; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 60; end
        3: begin send_idle_pct = 27; stall_pct = 27; end
        default: begin send_idle_pct = 0; stall_pct = 0; end
      endcase
      for (int n = 0; n < 140; n++) send_random_pair();
    end
    in_ch.valid <= 1'b0;
    stall_pct = 0;

    wait_drained();
    repeat (PipeDepth + 4) @(negedge clk);
    if (mismatches == 0 && pushes_due == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire
